// File: rtl/button_debounce_click_hold_macros.svh
// Assertion macros for the button debounce top level.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef BUTTON_DEBOUNCE_CLICK_HOLD_MACROS_SVH
`define BUTTON_DEBOUNCE_CLICK_HOLD_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BDCH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDCH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bdch_pkg.sv
// Package for the button debounce block: widths, reset values, codes and types.
// Used by the channel interfaces and the top level.
`default_nettype none

package bdch_pkg;

	localparam int NOW_W      = 32;
	localparam int DL_W       = 33;
	localparam int MS_W       = 16;
	localparam int CFG_IDX_W  = 2;

	// Event queue between the scan logic and the output channel.
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic            IDLE_LEVEL_RST = 1'b0;
	localparam logic [MS_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [MS_W-1:0] CLICK_WIN_RST  = 16'd500;
	localparam logic [MS_W-1:0] HOLD_RST       = 16'd2000;

	typedef enum logic [1:0] {
		EV_PRESS   = 2'd0,
		EV_RELEASE = 2'd1,
		EV_CLICK   = 2'd2,
		EV_HOLD    = 2'd3
	} event_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IDLE_LEVEL = 2'd0,
		REG_DEBOUNCE   = 2'd1,
		REG_CLICK_WIN  = 2'd2,
		REG_HOLD       = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		event_code_t code;
		logic        last;
	} evt_entry_t;

endpackage

`default_nettype wire

// File: rtl/bdch_ifs.sv
// Channel interfaces of the button debounce block: scan beats in, event beats out.
// Depends on bdch_pkg.
`default_nettype none

interface bdch_scan_if import bdch_pkg::*;;
	logic             valid;
	logic             ready;
	logic             pin_level;
	logic [NOW_W-1:0] now_ms;

	modport source (output valid, pin_level, now_ms, input ready);
	modport sink   (input valid, pin_level, now_ms, output ready);
endinterface

interface bdch_event_if import bdch_pkg::*;;
	logic        valid;
	logic        ready;
	event_code_t event_code;
	logic        last_event;

	modport source (output valid, event_code, last_event, input ready);
	modport sink   (input valid, event_code, last_event, output ready);
endinterface

`default_nettype wire

// File: rtl/button_debounce_click_hold.sv
// Top level of the button debounce block with press, release, click and hold events.
// Depends on bdch_pkg, the channel interfaces and the assertion macro header.
//
//   channel | dir | beat payload              | accepted when
//   scan    | in  | pin_level, now_ms         | scan.valid && scan.ready
//   evt     | out | event_code, last_event    | evt.valid && evt.ready
//   cfg     | in  | cfg_index, cfg_data       | cfg_we
//
// A scan beat is registered, evaluated in the next cycle and its events land in a
// four-entry event queue whose head drives the output beat.
// One scan beat per cycle is taken while scan.ready is high; the queue drains one
// event per cycle while evt.ready is high, and the output side limits two-event scans.
// scan.ready drops when the queued events plus those of the registered scan exceed two.
// Reset clears the debounce state and the queue and loads default config values.
`default_nettype none
`include "button_debounce_click_hold_macros.svh"

module button_debounce_click_hold import bdch_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [MS_W-1:0]      cfg_data,
	bdch_scan_if.sink                 scan,
	bdch_event_if.source              evt
);

	// Configuration registers.
	logic            idle_level_q;
	logic [MS_W-1:0] debounce_ms_q;
	logic [MS_W-1:0] click_ms_q;
	logic [MS_W-1:0] hold_ms_q;

	// Input register.
	logic             valid_s1;
	logic             pin_s1;
	logic [NOW_W-1:0] now_s1;

	// Debounce and event state.
	logic            pressed_q;
	logic            armed_q;
	logic [DL_W-1:0] deb_dl_q;
	logic [DL_W-1:0] click_dl_q;
	logic [DL_W-1:0] hold_dl_q;
	logic            hold_rep_q;

	// Event queue.
	evt_entry_t        queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	// Scan evaluation results.
	logic [DL_W-1:0] now33;
	logic [DL_W-1:0] deb_sum;
	logic [DL_W-1:0] click_sum;
	logic [DL_W-1:0] hold_sum;
	logic            mismatch;
	logic            toggle;
	logic            do_press;
	logic            do_release;
	logic            click_hit;
	logic            hold_hit;
	logic [1:0]      n_res;
	evt_entry_t      ent0;
	evt_entry_t      ent1;
	logic            pop;
	logic            push_ok;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_level_q  <= IDLE_LEVEL_RST;
			debounce_ms_q <= DEBOUNCE_RST;
			click_ms_q    <= CLICK_WIN_RST;
			hold_ms_q     <= HOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IDLE_LEVEL: idle_level_q  <= cfg_data[0];
				REG_DEBOUNCE:   debounce_ms_q <= cfg_data;
				REG_CLICK_WIN:  click_ms_q    <= cfg_data;
				REG_HOLD:       hold_ms_q     <= cfg_data;
			endcase
		end
	end

	// Input register: takes a beat whenever the queue has room for its events.
	assign scan.ready = push_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= scan.valid && scan.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			pin_s1 <= scan.pin_level;
			now_s1 <= scan.now_ms;
		end
	end

	// Evaluate the registered scan against the debounce state.
	always_comb begin
		logic            level;
		logic [DL_W-1:0] deb_eff;
		logic [DL_W-1:0] hold_dl_eff;
		logic            hold_rep_eff;
		logic            pressed_next;
		event_code_t     first_code;
		event_code_t     second_code;

		now33     = {1'b0, now_s1};
		deb_sum   = now33 + {{(DL_W-MS_W){1'b0}}, debounce_ms_q};
		click_sum = now33 + {{(DL_W-MS_W){1'b0}}, click_ms_q};
		hold_sum  = now33 + {{(DL_W-MS_W){1'b0}}, hold_ms_q};

		level      = pin_s1 ^ idle_level_q;
		mismatch   = valid_s1 && (level != pressed_q);
		deb_eff    = armed_q ? deb_dl_q : deb_sum;
		toggle     = mismatch && (now33 >= deb_eff);
		do_press   = toggle && !pressed_q;
		do_release = toggle && pressed_q;
		click_hit  = do_release && (now33 < click_dl_q);

		// A fresh press brings new hold deadline and clears the hold flag.
		hold_dl_eff  = do_press ? hold_sum : hold_dl_q;
		hold_rep_eff = do_press ? 1'b0 : hold_rep_q;
		pressed_next = pressed_q ^ toggle;
		hold_hit     = valid_s1 && pressed_next && !hold_rep_eff && (now33 >= hold_dl_eff);

		priority if (do_press) begin
			first_code  = EV_PRESS;
			second_code = EV_HOLD;
			n_res       = hold_hit ? 2'd2 : 2'd1;
		end else if (do_release) begin
			first_code  = EV_RELEASE;
			second_code = EV_CLICK;
			n_res       = click_hit ? 2'd2 : 2'd1;
		end else begin
			first_code  = EV_HOLD;
			second_code = EV_HOLD;
			n_res       = hold_hit ? 2'd1 : 2'd0;
		end

		ent0.code = first_code;
		ent0.last = (n_res == 2'd1);
		ent1.code = second_code;
		ent1.last = 1'b1;
	end

	// Debounce and event state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q  <= 1'b0;
			armed_q    <= 1'b0;
			deb_dl_q   <= '0;
			click_dl_q <= '0;
			hold_dl_q  <= '0;
			hold_rep_q <= 1'b0;
		end else if (valid_s1) begin
			pressed_q <= pressed_q ^ toggle;
			armed_q   <= mismatch && !toggle;
			if (mismatch && !armed_q) begin
				deb_dl_q <= deb_sum;
			end
			if (do_press) begin
				click_dl_q <= click_sum;
				hold_dl_q  <= hold_sum;
			end
			if (hold_hit) begin
				hold_rep_q <= 1'b1;
			end else if (do_press) begin
				hold_rep_q <= 1'b0;
			end
		end
	end

	// Event queue: up to two pushes and one pop per cycle.
	assign pop     = evt.valid && evt.ready;
	assign push_ok = ({1'b0, cnt_q} + {{(QCNT_W-1){1'b0}}, n_res}) <= (QCNT_W + 1)'(QDEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(n_res);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(n_res) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (n_res != 2'd0) begin
			queue_q[wr_ptr_q] <= ent0;
		end
		if (n_res == 2'd2) begin
			queue_q[wr_ptr_q + 1'b1] <= ent1;
		end
	end

	// Output beat comes straight from the queue head.
	assign evt.valid      = (cnt_q != '0);
	assign evt.event_code = queue_q[rd_ptr_q].code;
	assign evt.last_event = queue_q[rd_ptr_q].last;

	// Checks.
	`BDCH_ASSERT_NOW(a_queue_bound, 1'b1, cnt_q <= QCNT_W'(QDEPTH), "event queue overflow")
	`BDCH_ASSERT_NEXT(a_room_after_accept, scan.valid && scan.ready,
		cnt_q <= QCNT_W'(QDEPTH - 2), "scan accepted without room for its events")
	`BDCH_ASSERT_NEXT(a_state_idle_hold, !valid_s1, $stable(pressed_q),
		"debounced state changed without a scan")
	`BDCH_ASSERT_NOW(a_release_no_hold, do_release, !hold_hit,
		"hold reported on the release scan")

endmodule

`default_nettype wire
